### hdl/teoq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// teoq_pkg
// Shared types, codes and helpers for the timestamp ordered event queue.
// ----------------------------------------------------------------------------
package teoq_pkg;

  localparam int TIME_BITS    = 48;
  localparam int SEQ_BITS     = 32;
  localparam int PAYLOAD_BITS = 16;

  typedef enum logic {
    OP_PUBLISH = 1'b0,
    OP_DRAIN   = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_RELEASED = 2'd0,
    STAT_NONE_DUE = 2'd1,
    STAT_FULL     = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } back_state_t;

  typedef struct packed {
    opcode_t                 opcode;
    logic [TIME_BITS-1:0]    event_time;
    logic [SEQ_BITS-1:0]     event_seq;
    logic [PAYLOAD_BITS-1:0] event_payload;
    logic [TIME_BITS-1:0]    cutoff_time;
  } in_item_t;

  typedef struct packed {
    status_t                 status;
    logic [TIME_BITS-1:0]    out_time;
    logic [SEQ_BITS-1:0]     out_seq;
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]    tstamp;
    logic [SEQ_BITS-1:0]     seq;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  // classified command; a drain carries its cutoff in ev.tstamp
  typedef struct packed {
    opcode_t op;
    entry_t  ev;
  } cmd_t;

  // true when key a is strictly greater than key b
  function automatic logic key_after(entry_t a, entry_t b);
    if (a.tstamp != b.tstamp) begin
      return a.tstamp > b.tstamp;
    end
    return a.seq > b.seq;
  endfunction

endpackage
`default_nettype wire

### hdl/teoq_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// teoq_front
// Accepts command beats, classifies them and buffers them in a two-entry queue.
// ----------------------------------------------------------------------------
module teoq_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output      logic              busy,
  input  wire teoq_pkg::in_item_t item,
  output      logic              cmd_valid,
  output      teoq_pkg::cmd_t    cmd,
  input  wire logic              cmd_take
);

  teoq_pkg::cmd_t fifo_mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic [1:0]     count_next;
  teoq_pkg::cmd_t cmd_in;
  logic           push;
  logic           pop;

  // a drain only needs its cutoff, carried in the time field
  always_comb begin
    cmd_in.op = item.opcode;
    if (item.opcode == teoq_pkg::OP_DRAIN) begin
      cmd_in.ev.tstamp  = item.cutoff_time;
      cmd_in.ev.seq     = '0;
      cmd_in.ev.payload = '0;
    end else begin
      cmd_in.ev.tstamp  = item.event_time;
      cmd_in.ev.seq     = item.event_seq;
      cmd_in.ev.payload = item.event_payload;
    end
  end

  assign busy      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = fifo_mem[rd_ptr];
  assign push      = start && !busy;
  assign pop       = cmd_take && cmd_valid;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

### hdl/teoq_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// teoq_back
// Sorted shift-register store: inserts publishes, releases due events in order.
// ----------------------------------------------------------------------------
module teoq_back #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cmd_valid,
  input  wire teoq_pkg::cmd_t                   cmd,
  output      logic                             cmd_take,
  output      logic                             strobe,
  output      teoq_pkg::result_t                result,
  output      logic [$clog2(QUEUE_DEPTH+1)-1:0] occ
);

  localparam int OccBits = $clog2(QUEUE_DEPTH + 1);

  teoq_pkg::entry_t             slots      [QUEUE_DEPTH];
  teoq_pkg::entry_t             slots_next [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]       stay;
  logic [OccBits-1:0]           occupancy;
  logic [OccBits-1:0]           occupancy_next;
  logic [teoq_pkg::TIME_BITS-1:0] cutoff;
  logic [teoq_pkg::TIME_BITS-1:0] cutoff_next;
  logic [teoq_pkg::TIME_BITS-1:0] cut_sel;
  teoq_pkg::back_state_t        state;
  teoq_pkg::back_state_t        state_next;
  teoq_pkg::result_t            result_next;
  logic                         strobe_next;
  logic                         do_insert;
  logic                         do_release;
  logic                         head_due;
  logic                         next_due;
  logic                         full;

  assign occ     = occupancy;
  assign full    = (occupancy == OccBits'(QUEUE_DEPTH));
  assign cut_sel = (state == teoq_pkg::ST_IDLE) ? cmd.ev.tstamp : cutoff;
  assign head_due = (occupancy != '0) && (slots[0].tstamp <= cut_sel);
  assign next_due = (occupancy > OccBits'(1)) && (slots[1].tstamp <= cut_sel);

  // entries that keep their place on insert form a prefix
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      stay[i] = (OccBits'(i) < occupancy) && !teoq_pkg::key_after(slots[i], cmd.ev);
    end
  end

  always_comb begin
    cmd_take       = 1'b0;
    do_insert      = 1'b0;
    do_release     = 1'b0;
    strobe_next    = 1'b0;
    result_next    = '0;
    state_next     = state;
    cutoff_next    = cutoff;
    occupancy_next = occupancy;
    case (state)
      teoq_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          if (cmd.op == teoq_pkg::OP_PUBLISH) begin
            if (full) begin
              strobe_next        = 1'b1;
              result_next.status = teoq_pkg::STAT_FULL;
              result_next.last   = 1'b1;
            end else begin
              do_insert      = 1'b1;
              occupancy_next = occupancy + OccBits'(1);
            end
          end else begin
            cutoff_next = cmd.ev.tstamp;
            strobe_next = 1'b1;
            if (!head_due) begin
              result_next.status = teoq_pkg::STAT_NONE_DUE;
              result_next.last   = 1'b1;
            end else begin
              do_release = 1'b1;
              if (next_due) begin
                state_next = teoq_pkg::ST_DRAIN;
              end
            end
          end
        end
      end
      teoq_pkg::ST_DRAIN: begin
        strobe_next = 1'b1;
        do_release  = 1'b1;
        if (!next_due) begin
          state_next = teoq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = teoq_pkg::ST_IDLE;
      end
    endcase
    if (do_release) begin
      result_next.status      = teoq_pkg::STAT_RELEASED;
      result_next.out_time    = slots[0].tstamp;
      result_next.out_seq     = slots[0].seq;
      result_next.out_payload = slots[0].payload;
      result_next.last        = !next_due;
      occupancy_next          = occupancy - OccBits'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slots_next[i] = slots[i];
      if (do_insert) begin
        if (!stay[i]) begin
          if (i == 0) begin
            slots_next[i] = cmd.ev;
          end else if (stay[i-1]) begin
            slots_next[i] = cmd.ev;
          end else begin
            slots_next[i] = slots[i-1];
          end
        end
      end else if (do_release) begin
        if (i < QUEUE_DEPTH - 1) begin
          slots_next[i] = slots[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slots[i] <= slots_next[i];
    end
    cutoff <= cutoff_next;
    result <= result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= teoq_pkg::ST_IDLE;
      occupancy <= '0;
      strobe    <= 1'b0;
    end else begin
      state     <= state_next;
      occupancy <= occupancy_next;
      strobe    <= strobe_next;
    end
  end

endmodule
`default_nettype wire

### hdl/timestamp_ordered_event_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// timestamp_ordered_event_queue
// Bounded event queue kept sorted by (time, sequence); publish inserts,
// drain releases every event due by a cutoff in ascending order.
// ----------------------------------------------------------------------------
//  channel   ports                    handshake
//  command   start, busy, item        beat taken when start && !busy
//  result    strobe, result           one beat per strobe cycle, no backpressure
//
//  a publish is a single insert, or a full status when the store is full; a drain
//  releases its due events in turn, or gives one none-due status when none is due
//  the sorted shift-register store does one insert or one release per cycle;
//  a two-beat command queue in front takes beats during a drain until it is full
//  a command beat waits in the command queue and its result in the result register
//  reset clears the occupancy and the queues; slot contents need no clearing
//  the receiver cannot stall: every result is taken in its strobe cycle
// ----------------------------------------------------------------------------
module timestamp_ordered_event_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output      logic               busy,
  input  wire teoq_pkg::in_item_t item,
  output      logic               strobe,
  output      teoq_pkg::result_t  result
);

  logic                             cmd_valid;
  logic                             cmd_take;
  teoq_pkg::cmd_t                   cmd;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] occ;

  // front: accept and classify command beats, buffer them
  teoq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // back: sorted store, insert and drain sequencing, result register
  teoq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .strobe    (strobe),
    .result    (result),
    .occ       (occ)
  );

  // store never holds more than its depth
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

  // status beats other than a release always close their command
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.status != teoq_pkg::STAT_RELEASED) |-> result.last)
    else $error("status beat without last");

  // released events of one drain come out in ascending time
  a_drain_order: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.status == teoq_pkg::STAT_RELEASED &&
     $past(strobe && result.status == teoq_pkg::STAT_RELEASED && !result.last))
    |-> (result.out_time >= $past(result.out_time)))
    else $error("drain released out of order");

  // a drain in progress keeps strobing until its last beat
  a_drain_cont: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.status == teoq_pkg::STAT_RELEASED && !result.last) |=> strobe)
    else $error("drain stopped before last beat");

endmodule
`default_nettype wire
